[rtl/edf_tick_scheduler_macros.svh]
// Assertion macros for the EDF tick scheduler checker.
// Included by the checker file; holds nothing but defines.
`ifndef EDF_TICK_SCHEDULER_MACROS_SVH
`define EDF_TICK_SCHEDULER_MACROS_SVH

// Clocked assertion, disabled while reset is low
`define EDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define EDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/edf_pkg.sv]
// Shared types and constants for the EDF tick scheduler.
// No dependencies; used by the scheduler core and the top level.
`timescale 1ns / 1ps

package edf_pkg;

    // Number of task slots held in the slot memory (2 .. 16)
    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    // Fixed field widths of the stream items
    localparam int TASK_ID_W = 4;
    localparam int CFG_W     = 5;
    localparam int TIME_W    = 16;
    localparam int DL_W      = 32;

    // Action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // One slot of the task memory
    typedef struct packed {
        logic [TIME_W-1:0] exec_time;
        logic [TIME_W-1:0] period;
        logic [DL_W-1:0]   deadline;
        logic [TIME_W-1:0] work_left;
    } t_slot;

    // Input item as seen by the core
    typedef struct packed {
        logic                 action;
        logic [TASK_ID_W-1:0] task_index;
        logic [TIME_W-1:0]    exec_time;
        logic [TIME_W-1:0]    period;
    } t_req;

    // Result item from the core
    typedef struct packed {
        logic [TASK_ID_W-1:0] task_id;
        logic                 idle;
        logic                 job_done;
    } t_res;

    // Core sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_UPD
    } t_state;

endpackage

[rtl/edf_tick_scheduler.sv]
// A load item (tuser 0) writes one task slot with its execution time and period; the
// deadline starts at the period. A tick item (tuser 1) runs the task with the earliest
// deadline that still has work, ties to the lower slot, and returns one result naming it
// or flagging idle. Task state lives in a one-port-read slot memory that a tick scans one
// slot per cycle (task_count saturated to the slot count; no scan when it is zero). Input is
// held off from a tick's transfer until its result enters the result register, and
// longer while that register stays full; a load gives no result.
// Top level of the EDF tick scheduler: config register, stream ports, result register.
// Depends on edf_pkg and edf_sched_core.
`timescale 1ns / 1ps

module edf_tick_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Config: task_count
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [3:0] task_index, [19:4] exec_time,
                                       // [35:20] period, [39:36] zero
    input  logic        s_axis_tuser,  // [0] action
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [3:0] task_id, [4] job_done, [7:5] zero
    output logic        m_axis_tuser   // [0] idle
);

    logic [edf_pkg::CFG_W-1:0] r_task_count;
    edf_pkg::t_req             w_req;
    edf_pkg::t_res             w_res;
    edf_pkg::t_res             r_out;
    logic                      r_out_valid;
    logic                      w_res_valid;
    logic                      w_res_ready;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= edf_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            r_task_count <= i_cfg_wdata;
        end
    end

    // Unpack the input transfer
    assign w_req.action     = s_axis_tuser;
    assign w_req.task_index = s_axis_tdata[3:0];
    assign w_req.exec_time  = s_axis_tdata[19:4];
    assign w_req.period     = s_axis_tdata[35:20];

    edf_sched_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_req        (w_req),
        .i_task_count (r_task_count),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    // Result register: take a new result when empty or being drained
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    // Pack the result transfer
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.job_done, r_out.task_id};
    assign m_axis_tuser  = r_out.idle;

endmodule

[rtl/edf_sched_core.sv]
// EDF scheduler core: slot memory, deadline scan and write-back sequencer.
// Depends on edf_pkg for types, widths and state codes.
`timescale 1ns / 1ps

module edf_sched_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  edf_pkg::t_req              i_req,
    input  logic [edf_pkg::CFG_W-1:0]  i_task_count,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output edf_pkg::t_res              o_res
);

    // Slot memory, one synchronous read port and one write port
    edf_pkg::t_slot mem [edf_pkg::MAX_TASKS];
    edf_pkg::t_slot r_rd_data;

    edf_pkg::t_state r_state, n_state;

    logic [edf_pkg::IDX_W-1:0] r_addr;
    logic [edf_pkg::IDX_W-1:0] r_cmp_idx;
    logic                      r_cmp_valid;
    logic [edf_pkg::IDX_W-1:0] r_best_idx;
    edf_pkg::t_slot            r_best;
    logic                      r_found;

    logic [edf_pkg::CNT_W-1:0] w_limit;
    logic                      w_tick_go;
    logic                      w_load_go;
    logic                      w_load_ok;
    logic                      w_scan_end;
    logic                      w_better;
    logic                      w_we;
    logic [edf_pkg::IDX_W-1:0] w_waddr;
    edf_pkg::t_slot            w_wdata;
    edf_pkg::t_slot            w_upd;
    logic [edf_pkg::TIME_W-1:0] w_work_dec;
    logic                      w_done;

    // Saturate the slot count to the memory depth
    always_comb begin
        if (32'(i_task_count) > 32'(edf_pkg::MAX_TASKS)) begin
            w_limit = edf_pkg::CNT_W'(edf_pkg::MAX_TASKS);
        end else begin
            w_limit = edf_pkg::CNT_W'(i_task_count);
        end
    end

    assign w_tick_go  = (r_state == edf_pkg::S_IDLE) && i_req_valid
                        && (i_req.action == edf_pkg::ACT_TICK);
    assign w_load_go  = (r_state == edf_pkg::S_IDLE) && i_req_valid
                        && (i_req.action == edf_pkg::ACT_LOAD);
    assign w_load_ok  = 32'(i_req.task_index) < 32'(edf_pkg::MAX_TASKS);
    assign w_scan_end = edf_pkg::CNT_W'(r_addr) == (w_limit - edf_pkg::CNT_W'(1));

    // Candidate beats the best so far: has work and an earlier deadline
    assign w_better = r_cmp_valid && (r_rd_data.work_left != '0)
                      && (!r_found || (r_rd_data.deadline < r_best.deadline));

    // Retire one tick of work on the chosen slot
    assign w_work_dec = r_best.work_left - edf_pkg::TIME_W'(1);
    assign w_done     = (w_work_dec == '0);
    always_comb begin
        w_upd = r_best;
        if (w_done) begin
            w_upd.deadline  = r_best.deadline + edf_pkg::DL_W'(r_best.period);
            w_upd.work_left = r_best.exec_time;
        end else begin
            w_upd.work_left = w_work_dec;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            edf_pkg::S_IDLE: begin
                if (w_tick_go) begin
                    n_state = (w_limit == '0) ? edf_pkg::S_UPD : edf_pkg::S_SCAN;
                end
            end
            edf_pkg::S_SCAN: begin
                if (w_scan_end) begin
                    n_state = edf_pkg::S_LAST;
                end
            end
            edf_pkg::S_LAST: begin
                n_state = edf_pkg::S_UPD;
            end
            edf_pkg::S_UPD: begin
                if (i_res_ready) begin
                    n_state = edf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = edf_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and memory write port
    always_comb begin
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_best_idx;
        w_wdata     = w_upd;
        case (r_state)
            edf_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (w_load_go && w_load_ok) begin
                    w_we    = 1'b1;
                    w_waddr = edf_pkg::IDX_W'(i_req.task_index);
                    w_wdata = '{exec_time: i_req.exec_time,
                                period:    i_req.period,
                                deadline:  edf_pkg::DL_W'(i_req.period),
                                work_left: i_req.exec_time};
                end
            end
            edf_pkg::S_UPD: begin
                o_res_valid = 1'b1;
                w_we        = r_found && i_res_ready;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    // Result fields; idle ticks report zeros
    assign o_res.task_id  = r_found ? edf_pkg::TASK_ID_W'(r_best_idx) : '0;
    assign o_res.idle     = !r_found;
    assign o_res.job_done = r_found && w_done;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= edf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan address and compare tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_cmp_valid <= (r_state == edf_pkg::S_SCAN);
            if (w_tick_go) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end else begin
                if (r_state == edf_pkg::S_SCAN) begin
                    r_addr <= r_addr + edf_pkg::IDX_W'(1);
                end
                if (w_better) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // Hold the best candidate so the update needs no second read
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr;
        if (w_better) begin
            r_best_idx <= r_cmp_idx;
            r_best     <= r_rd_data;
        end
    end

    // Memory read, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_addr];
    end

    // Memory write
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

endmodule

[rtl/edf_tick_scheduler_chk.sv]
// Port-level checker for the EDF tick scheduler, bound to the top level.
// Depends on edf_tick_scheduler_macros.svh.
`timescale 1ns / 1ps
`include "edf_tick_scheduler_macros.svh"

module edf_tick_scheduler_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser
);

    // A pending result stays until transferred
    `EDF_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped before transfer")

    // An idle result carries no task and no job completion
    `EDF_ASSERT(a_idle_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'h00, "idle result with nonzero fields")

    // A tick occupies the scan, so input is held off in the next cycle
    `EDF_ASSERT(a_tick_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready, "input ready right after a tick")

    // A load never produces a result
    `EDF_ASSERT(a_load_quiet, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !$rose(m_axis_tvalid), "result raised by a load")

endmodule

bind edf_tick_scheduler edf_tick_scheduler_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/testbench.sv]
// Self-checking bench for edf_tick_scheduler: drives load and tick transfers,
// predicts every tick result from its own copy of the slot table, and checks them.
// Depends on edf_pkg and the edf_tick_scheduler RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = edf_pkg::MAX_TASKS + 8;
    localparam int QUIET_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 240;

    // Slot table mirror, expected tick picks and mismatch count
    class tick_ledger;
        bit [15:0] exec_ticks   [edf_pkg::MAX_TASKS];
        bit [15:0] period_ticks [edf_pkg::MAX_TASKS];
        bit [31:0] deadline     [edf_pkg::MAX_TASKS];
        bit [15:0] work_left    [edf_pkg::MAX_TASKS];
        bit [4:0]  task_count = 5'd1;
        edf_pkg::t_res pending_picks [$];
        int errors;
        int results_seen;

        function int pending();
            return pending_picks.size();
        endfunction

        function void set_task_count(logic [4:0] value);
            task_count = value;
        endfunction

        // Run one tick on the mirror: earliest deadline with work, ties to the lower slot
        function edf_pkg::t_res pick_task();
            edf_pkg::t_res pick;
            int limit;
            int best;
            bit found;
            pick  = '0;
            best  = 0;
            found = 1'b0;
            limit = (task_count > edf_pkg::MAX_TASKS) ? edf_pkg::MAX_TASKS : task_count;
            for (int i = 0; i < limit; i++) begin
                if (work_left[i] != 0 && (!found || deadline[i] < deadline[best])) begin
                    found = 1'b1;
                    best  = i;
                end
            end
            if (!found) begin
                pick.idle = 1'b1;
                return pick;
            end
            work_left[best]--;
            // Job finished: advance the deadline by one period and reload the work
            if (work_left[best] == 0) begin
                deadline[best] += period_ticks[best];
                work_left[best] = exec_ticks[best];
                pick.job_done   = 1'b1;
            end
            pick.task_id = best[3:0];
            return pick;
        endfunction

        function void note_item(logic act, logic [3:0] idx, logic [15:0] ex,
                                logic [15:0] per);
            if (act == edf_pkg::ACT_LOAD) begin
                if (idx < edf_pkg::MAX_TASKS) begin
                    exec_ticks[idx]   = ex;
                    period_ticks[idx] = per;
                    deadline[idx]     = {16'h0, per};
                    work_left[idx]    = ex;
                end
            end else begin
                pending_picks.push_back(pick_task());
            end
        endfunction

        task report_mismatch(string what);
            $display("mismatch at result %0d: %s", results_seen, what);
            errors++;
        endtask

        task check_result(logic [3:0] task_id, logic idle, logic job_done);
            edf_pkg::t_res want;
            results_seen++;
            if (pending_picks.size() == 0) begin
                report_mismatch("result with no tick outstanding");
                return;
            end
            want = pending_picks.pop_front();
            if (idle !== want.idle)
                report_mismatch($sformatf("idle %b, expected %b", idle, want.idle));
            if (task_id !== want.task_id)
                report_mismatch($sformatf("task_id %0d, expected %0d",
                                          task_id, want.task_id));
            if (job_done !== want.job_done)
                report_mismatch($sformatf("job_done %b, expected %b",
                                          job_done, want.job_done));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;

    tick_ledger ledger = new();

    int tx_gap_pct;
    int rx_stall_pct;
    int hold_requests;
    int holds_served;
    int hold_left;
    int quiet_cycles;

    edf_tick_scheduler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested
    always @(posedge i_clk) begin
        if (hold_left == 0 && holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Sample transfers and config writes; end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                ledger.check_result(m_axis_tdata[3:0], m_axis_tuser, m_axis_tdata[4]);
            if (s_axis_tvalid && s_axis_tready)
                ledger.note_item(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[19:4],
                                 s_axis_tdata[35:20]);
            if (i_cfg_we)
                ledger.set_task_count(i_cfg_wdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Offer one item, with random idle cycles first, and hold it until the transfer
    task automatic push_item(input logic act, input logic [3:0] idx,
                             input logic [15:0] ex, input logic [15:0] per);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'h0, per, ex, idx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop offering and wait for every outstanding tick result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (ledger.pending() != 0);
    endtask

    task automatic write_task_count(input logic [4:0] value);
        drain_results();
        // A load may still be in flight after the last result
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One random item: mostly ticks, loads aimed at active slots with short jobs
    task automatic random_item(input int active);
        logic [3:0]  idx;
        logic [15:0] ex;
        logic [15:0] per;
        int roll;
        if ($urandom_range(99) < 60) begin
            push_item(edf_pkg::ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            if (active > 0 && $urandom_range(9) < 8)
                idx = 4'($urandom_range(active - 1));
            else
                idx = 4'($urandom_range(15));
            roll = $urandom_range(99);
            if (roll < 8)
                ex = 16'd0;
            else if (roll < 18)
                ex = 16'($urandom);
            else
                ex = 16'($urandom_range(1, 6));
            roll = $urandom_range(99);
            if (roll < 5)
                per = 16'd0;
            else if (roll < 15)
                per = 16'($urandom);
            else
                per = 16'($urandom_range(1, 40));
            push_item(edf_pkg::ACT_LOAD, idx, ex, per);
        end
    endtask

    initial begin
        logic [4:0] count;
        int active;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 5'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = edf_pkg::ACT_LOAD;
        m_axis_tready = 1'b0;
        tx_gap_pct    = 0;
        rx_stall_pct  = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Slot 0 alone under the reset task count
        push_item(edf_pkg::ACT_LOAD, 4'd0, 16'd2, 16'd5);
        repeat (3) push_item(edf_pkg::ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
        write_task_count(5'd16);

        // Fill the rest: zero work, field extremes, a tie at deadline zero, tied pairs
        push_item(edf_pkg::ACT_LOAD, 4'd1, 16'd0, 16'd3);
        push_item(edf_pkg::ACT_LOAD, 4'd2, 16'hFFFF, 16'hFFFF);
        push_item(edf_pkg::ACT_LOAD, 4'd3, 16'd1, 16'd0);
        push_item(edf_pkg::ACT_LOAD, 4'd6, 16'd2, 16'd0);
        for (int s = 4; s < edf_pkg::MAX_TASKS; s++)
            if (s != 6)
                push_item(edf_pkg::ACT_LOAD, s[3:0], 16'(s), 16'(1 + s / 2));
        repeat (3) push_item(edf_pkg::ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom));

        // Retire the zero-period tasks so the tied pair gets picked
        push_item(edf_pkg::ACT_LOAD, 4'd3, 16'd0, 16'd7);
        push_item(edf_pkg::ACT_LOAD, 4'd6, 16'd0, 16'd7);
        repeat (3) push_item(edf_pkg::ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom));

        // Random phases, each with its own task count and idling pattern
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: count = 5'd16;
                1: count = 5'd31;
                2: count = 5'd0;
                3: count = 5'd1;
                4: count = 5'd5;
                default: count = 5'($urandom_range(2, 15));
            endcase
            write_task_count(count);
            active = (count > edf_pkg::MAX_TASKS) ? edf_pkg::MAX_TASKS : count;
            case (ph % 4)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 49; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 49; end
                default: begin tx_gap_pct = 22; rx_stall_pct = 22; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 60)
                    hold_requests++;
                if (ph == 0 && n == 150)
                    drain_results();
                random_item(active);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
